// ----- hw/rtl/wdnre_pkg.sv -----
// shared constants and types for the wide decimal narrowing block
// no dependencies; imported by wdnre_div10 and wide_decimal_narrow_round_even
package wdnre_pkg;

  // mantissa is walked in 28-bit limbs so one limb step fits a 32x32 multiply
  localparam int unsigned LimbW       = 28;
  localparam int unsigned NumLimbs    = 8;
  localparam int unsigned MantW       = LimbW * NumLimbs;
  localparam int unsigned RemW        = 4;
  localparam int unsigned StepW       = RemW + LimbW;
  localparam int unsigned CntW        = $clog2(NumLimbs);
  localparam int unsigned ScaleW      = 8;
  localparam int unsigned ResW        = 96;
  localparam int unsigned ResLowW     = 64;
  localparam int unsigned ResHighW    = 32;
  localparam int unsigned ResScaleW   = 5;
  localparam int unsigned StatW       = 2;
  localparam int unsigned MaxScaleDef = 28;

  // floor(x / 10) == (x * Recip10) >> RecipShift for every 32-bit x
  localparam int unsigned RecipShift  = 35;
  localparam logic [31:0] Recip10     = 32'd3435973837;

  localparam logic [RemW-1:0] HalfDigit = 4'd5;

  localparam logic [StatW-1:0] StOk       = 2'd0;
  localparam logic [StatW-1:0] StTooLarge = 2'd1;
  localparam logic [StatW-1:0] StTooSmall = 2'd2;

  typedef logic [LimbW-1:0] limb_t;
  typedef logic [RemW-1:0]  rem_t;

endpackage

// ----- hw/rtl/wdnre_div10.sv -----
// one limb step of a long division by ten
// takes the running remainder and the next limb; depends on wdnre_pkg
module wdnre_div10 (
  input  wdnre_pkg::rem_t  rem_i,
  input  wdnre_pkg::limb_t limb_i,
  output wdnre_pkg::limb_t quot_o,
  output wdnre_pkg::rem_t  rem_o
);
  import wdnre_pkg::*;

  logic [StepW-1:0]   x;
  logic [2*StepW-1:0] prod;
  limb_t              quot;
  logic [StepW-1:0]   back;

  assign x    = {rem_i, limb_i};
  // reciprocal multiply, exact since rem_i < 10 keeps x below 10 * 2^28
  assign prod = {{StepW{1'b0}}, x} * {{StepW{1'b0}}, Recip10};
  assign quot = prod[RecipShift +: LimbW];
  // quot * 10 as shift-add
  assign back = StepW'({quot, 3'b000}) + StepW'({quot, 1'b0});

  assign quot_o = quot;
  assign rem_o  = RemW'(x - back);

endmodule

// ----- hw/rtl/wide_decimal_narrow_round_even.sv -----
// each word takes n divide-by-ten steps (n <= scale_in_i)
// the output state stalls while the result register is full
// each step walks the 224-bit mantissa through one shared divide-by-ten unit,
// one 28-bit limb per cycle, then a rounding state and a check state
// one word in flight; in_ready_o is high only while the sequencer is idle, and the result
// register lets the next word enter while a result waits; async reset clears sequencer and valid
module wide_decimal_narrow_round_even #(
  parameter int unsigned MaxScale = wdnre_pkg::MaxScaleDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [63:0]                         mant_w0_i,
  input  logic [63:0]                         mant_w1_i,
  input  logic [63:0]                         mant_w2_i,
  input  logic [31:0]                         mant_w3_i,
  input  logic                                sign_in_i,
  input  logic [wdnre_pkg::ScaleW-1:0]        scale_in_i,
  input  logic [wdnre_pkg::StatW-1:0]         incoming_status_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wdnre_pkg::ResLowW-1:0]       res_low_o,
  output logic [wdnre_pkg::ResHighW-1:0]      res_high_o,
  output logic                                res_sign_o,
  output logic [wdnre_pkg::ResScaleW-1:0]     res_scale_o,
  output logic [wdnre_pkg::StatW-1:0]         status_o
);
  import wdnre_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;
  localparam logic [2:0] SDiv   = 3'd2;
  localparam logic [2:0] SRound = 3'd3;
  localparam logic [2:0] SOut   = 3'd4;

  localparam logic [CntW-1:0]   LastLimb = CntW'(NumLimbs - 1);
  localparam logic [ScaleW-1:0] MaxScl   = ScaleW'(MaxScale);

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [MantW-1:0]  mant_q, mant_d;
  rem_t              rem_q, rem_d;
  logic [ScaleW-1:0] scale_q, scale_d;
  logic              sign_q, sign_d;
  logic [StatW-1:0]  stat_q, stat_d;
  logic              was_zero_q, was_zero_d;

  logic                 out_valid_q, out_valid_d;
  logic [ResLowW-1:0]   res_low_q, res_low_d;
  logic [ResHighW-1:0]  res_high_q, res_high_d;
  logic                 res_sign_q, res_sign_d;
  logic [ResScaleW-1:0] res_scale_q, res_scale_d;
  logic [StatW-1:0]     status_q, status_d;

  limb_t      div_quot;
  rem_t       div_rem;
  logic       upper_nz;
  logic       mant_zero;
  logic       round_up;
  logic       more_steps;
  logic       out_load;
  logic [StatW-1:0] final_stat;

  wdnre_div10 u_div10 (
    .rem_i  (rem_q),
    .limb_i (mant_q[MantW-1 -: LimbW]),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign upper_nz   = |mant_q[MantW-1:ResW];
  assign mant_zero  = ~|mant_q;
  assign round_up   = (rem_q > HalfDigit) || ((rem_q == HalfDigit) && mant_q[0]);
  assign more_steps = (scale_q > MaxScl) || (upper_nz && (scale_q != '0));
  assign out_load   = (state_q == SOut) && (!out_valid_q || out_ready_i);

  // an underflowed value stays zero, so the check can wait for the end
  always_comb begin
    final_stat = stat_q;
    if (!was_zero_q && mant_zero) final_stat = StTooSmall;
    if (upper_nz) final_stat = sign_q ? StTooSmall : StTooLarge;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    mant_d     = mant_q;
    rem_d      = rem_q;
    scale_d    = scale_q;
    sign_d     = sign_q;
    stat_d     = stat_q;
    was_zero_d = was_zero_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          mant_d     = {mant_w3_i, mant_w2_i, mant_w1_i, mant_w0_i};
          scale_d    = scale_in_i;
          sign_d     = sign_in_i;
          stat_d     = incoming_status_i;
          was_zero_d = ~|{mant_w3_i, mant_w2_i, mant_w1_i, mant_w0_i};
          state_d    = SCheck;
        end
      end
      SCheck: begin
        cnt_d = '0;
        rem_d = '0;
        state_d = more_steps ? SDiv : SOut;
      end
      SDiv: begin
        // top limb goes through the divider, quotient rotates in at the bottom
        mant_d = {mant_q[MantW-LimbW-1:0], div_quot};
        rem_d  = div_rem;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LastLimb) state_d = SRound;
      end
      SRound: begin
        if (round_up) mant_d = mant_q + 1'b1;
        scale_d = scale_q - 1'b1;
        state_d = SCheck;
      end
      SOut: begin
        if (out_load) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_low_d   = res_low_q;
    res_high_d  = res_high_q;
    res_sign_d  = res_sign_q;
    res_scale_d = res_scale_q;
    status_d    = status_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      status_d    = final_stat;
      if (final_stat == StOk) begin
        res_low_d   = mant_q[ResLowW-1:0];
        res_high_d  = mant_q[ResW-1:ResLowW];
        res_sign_d  = sign_q;
        res_scale_d = scale_q[ResScaleW-1:0];
      end else begin
        res_low_d   = '0;
        res_high_d  = '0;
        res_sign_d  = 1'b0;
        res_scale_d = '0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q      <= mant_d;
    rem_q       <= rem_d;
    scale_q     <= scale_d;
    sign_q      <= sign_d;
    stat_q      <= stat_d;
    was_zero_q  <= was_zero_d;
    res_low_q   <= res_low_d;
    res_high_q  <= res_high_d;
    res_sign_q  <= res_sign_d;
    res_scale_q <= res_scale_d;
    status_q    <= status_d;
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign res_low_o   = res_low_q;
  assign res_high_o  = res_high_q;
  assign res_sign_o  = res_sign_q;
  assign res_scale_o = res_scale_q;
  assign status_o    = status_q;

  // an error word carries an all-zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StOk)) |->
      ((res_low_o == '0) && (res_high_o == '0) && !res_sign_o && (res_scale_o == '0)))
    else $error("error word with nonzero payload");

  // rounding only after all limbs went through the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRound) |-> (($past(state_q) == SDiv) && ($past(cnt_q) == LastLimb)))
    else $error("rounding before the limb walk finished");

  // a new word shows up only out of the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == SOut))
    else $error("output valid raised outside the output state");

  // no word is taken while a step is in progress; checked as no return to idle straight after rounding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SDiv) || (state_q == SRound)) |=> (state_q != SIdle) || $past(state_q == SRound) == 1'b0)
    else $error("sequencer left a step early");

endmodule
